// File: rtl/lbc_pkg.sv
// lbc_pkg: shared types and constants of the lru block cache
`default_nettype none
package lbc_pkg;

  localparam int unsigned IDX_W   = 12;  // widest entry index (4096 entries)
  localparam int unsigned LIVE_W  = 13;  // entry count up to 4096
  localparam int unsigned CFG_W   = 9;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_UPDATE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_DUP  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_INSERT  = 2'd1,
    TGT_UPDATE  = 2'd2,
    TGT_REFUSED = 2'd3
  } target_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_READ
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [3:0]  disk;
    logic [7:0]  block;
    logic [4:0]  word_index;
    logic [63:0] data_word;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] read_word;
    logic        last;
    logic [31:0] hit_count;
    logic [31:0] query_count;
  } res_t;

  // search word handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_idx;
    logic             has_free;
    logic [IDX_W-1:0] free_idx;
    logic             has_min;
    logic [31:0]      min_stamp;
    logic [IDX_W-1:0] min_idx;
  } carry_t;

  // write to one entry of the tag chain
  typedef struct packed {
    logic             en;
    logic             tag;
    logic [IDX_W-1:0] idx;
    logic [3:0]       disk;
    logic [7:0]       block;
    logic [31:0]      stamp;
  } ent_wr_t;

endpackage
`default_nettype wire

// File: rtl/lbc_ram.sv
// lbc_ram: single write port, single registered read port memory
`default_nettype none
module lbc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/lbc_cell.sv
// lbc_cell: one cache entry tag and stamp, one step of the search chain
`default_nettype none
module lbc_cell import lbc_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [LIVE_W-1:0] live_i,
  input  wire logic [3:0]        disk_i,
  input  wire logic [7:0]        block_i,
  input  wire ent_wr_t           wr_i,
  input  wire carry_t            carry_i,
  output carry_t                 carry_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic        valid_q;
  logic [3:0]  disk_q;
  logic [7:0]  block_q;
  logic [31:0] stamp_q;
  carry_t      carry_d;
  logic        in_use;
  logic        sel;

  assign in_use = LIVE_W'(IDX) < live_i;
  assign sel    = wr_i.en && (wr_i.idx == MY_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      disk_q  <= '0;
      block_q <= '0;
      stamp_q <= '0;
    end else if (sel) begin
      stamp_q <= wr_i.stamp;
      if (wr_i.tag) begin
        valid_q <= 1'b1;
        disk_q  <= wr_i.disk;
        block_q <= wr_i.block;
      end
    end
  end

  always_comb begin
    carry_d = carry_i;
    if (in_use) begin
      if (valid_q && disk_q == disk_i && block_q == block_i && !carry_i.found) begin
        carry_d.found     = 1'b1;
        carry_d.match_idx = MY_IDX;
      end
      if (!valid_q && !carry_i.has_free) begin
        carry_d.has_free = 1'b1;
        carry_d.free_idx = MY_IDX;
      end
      // strict compare keeps the lowest index among equal stamps
      if (valid_q && (!carry_i.has_min || stamp_q < carry_i.min_stamp)) begin
        carry_d.has_min   = 1'b1;
        carry_d.min_stamp = stamp_q;
        carry_d.min_idx   = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    carry_o <= carry_d;
  end

endmodule
`default_nettype wire

// File: rtl/lru_block_cache.sv
// lru_block_cache: top level, control sequencer, cell chain and block memory
`default_nettype none
// Fully associative LRU block cache. A lookup, and beat 0 of an insert or an
// update, runs a search word through the chain of ENTRIES tag cells, one cell
// a cycle, with busy_o high until the decision; a lookup hit then reads
// BLOCK_WORDS words from the block memory, one per cycle, with busy_o still
// high. Other insert or update beats, unused actions and lookups before any
// stamp do not raise busy_o. Each result shows on res_o in the cycle after the
// cycle that makes it, for one cycle with done_o, and cannot be held off;
// busy_o is high while a search or a block read is in progress.
module lru_block_cache import lbc_pkg::*; #(
  parameter int unsigned ENTRIES     = 256,
  parameter int unsigned BLOCK_WORDS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire req_t        req_i,
  output logic             done_o,
  output res_t             res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IW    = $clog2(ENTRIES);
  localparam int unsigned AW    = $clog2(ENTRIES * BLOCK_WORDS);
  localparam int unsigned CNT_W = ($clog2(ENTRIES + 1) > 5) ? $clog2(ENTRIES + 1) : 5;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  req_t             item_q, item_d;
  logic [31:0]      stamp_q, stamp_d, hits_q, hits_d, queries_q, queries_d;
  logic [IW-1:0]    tgt_q, tgt_d, rd_base_q, rd_base_d;
  target_e          tgt_ok_q, tgt_ok_d;
  logic [CFG_W-1:0] cfg_q;
  logic             done_q, done_d, last_q, last_d, use_ram_q, use_ram_d;
  status_e          status_q, status_d;

  logic [LIVE_W-1:0] live;
  ent_wr_t           ent_wr;
  carry_t            chain [ENTRIES];
  carry_t            fin;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [63:0]       ram_wdata, ram_rdata;

  // beat handling
  logic              beat_go;
  req_t              beat_item;
  target_e           beat_ok;
  logic [IW-1:0]     beat_tgt;
  logic [IW-1:0]     victim;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - CFG_W){1'b0}}, cfg_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_W'(256);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      cfg_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      live = LIVE_W'(1);
    end else if (32'(cfg_q) > ENTRIES) begin
      live = LIVE_W'(ENTRIES);
    end else begin
      live = LIVE_W'(cfg_q);
    end
  end

  // tag chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    carry_t cin;
    if (i == 0) begin : g_head
      assign cin = '0;
    end else begin : g_link
      assign cin = chain[i-1];
    end
    lbc_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .live_i  (live),
      .disk_i  (item_q.disk),
      .block_i (item_q.block),
      .wr_i    (ent_wr),
      .carry_i (cin),
      .carry_o (chain[i])
    );
  end

  assign fin    = chain[ENTRIES-1];
  assign victim = fin.has_free ? fin.free_idx[IW-1:0] : fin.min_idx[IW-1:0];

  lbc_ram #(.WIDTH(64), .DEPTH(ENTRIES * BLOCK_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      stamp_q   <= '0;
      hits_q    <= '0;
      queries_q <= '0;
      tgt_q     <= '0;
      tgt_ok_q  <= TGT_NONE;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      stamp_q   <= stamp_d;
      hits_q    <= hits_d;
      queries_q <= queries_d;
      tgt_q     <= tgt_d;
      tgt_ok_q  <= tgt_ok_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    rd_base_q <= rd_base_d;
    status_q  <= status_d;
    last_q    <= last_d;
    use_ram_q <= use_ram_d;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    item_d    = item_q;
    stamp_d   = stamp_q;
    hits_d    = hits_q;
    queries_d = queries_q;
    tgt_d     = tgt_q;
    tgt_ok_d  = tgt_ok_q;
    rd_base_d = rd_base_q;
    done_d    = 1'b0;
    status_d  = STS_MISS;
    last_d    = 1'b1;
    use_ram_d = 1'b0;
    ent_wr    = '0;
    ram_re    = 1'b0;
    ram_raddr = AW'(rd_base_q) * AW'(BLOCK_WORDS) + AW'(cnt_q);
    beat_go   = 1'b0;
    beat_item = item_q;
    beat_ok   = tgt_ok_q;
    beat_tgt  = tgt_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d = req_i;
          cnt_d  = '0;
          case (req_i.action) inside
            ACT_LOOKUP: begin
              if (stamp_q == '0) begin
                done_d = 1'b1;
              end else begin
                queries_d = queries_q + 32'd1;
                state_d   = S_SEARCH;
              end
            end
            ACT_INSERT, ACT_UPDATE: begin
              if (req_i.word_index == '0) begin
                state_d = S_SEARCH;
              end else begin
                beat_go   = 1'b1;
                beat_item = req_i;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_SEARCH: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ENTRIES)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
          case (item_q.action)
            ACT_LOOKUP: begin
              if (fin.found) begin
                hits_d       = hits_q + 32'd1;
                stamp_d      = stamp_q + 32'd1;
                ent_wr.en    = 1'b1;
                ent_wr.idx   = fin.match_idx;
                ent_wr.stamp = stamp_q + 32'd1;
                rd_base_d    = fin.match_idx[IW-1:0];
                state_d      = S_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            ACT_INSERT: begin
              beat_go = 1'b1;
              if (fin.found) begin
                beat_ok = TGT_REFUSED;
              end else begin
                stamp_d      = stamp_q + 32'd1;
                ent_wr.en    = 1'b1;
                ent_wr.tag   = 1'b1;
                ent_wr.idx   = IDX_W'(victim);
                ent_wr.disk  = item_q.disk;
                ent_wr.block = item_q.block;
                ent_wr.stamp = stamp_q + 32'd1;
                beat_ok      = TGT_INSERT;
                beat_tgt     = victim;
              end
            end
            default: begin
              beat_go = 1'b1;
              if (fin.found) begin
                stamp_d      = stamp_q + 32'd1;
                ent_wr.en    = 1'b1;
                ent_wr.idx   = fin.match_idx;
                ent_wr.stamp = stamp_q + 32'd1;
                beat_ok      = TGT_UPDATE;
                beat_tgt     = fin.match_idx[IW-1:0];
              end else begin
                beat_ok = TGT_NONE;
              end
            end
          endcase
        end
      end

      S_READ: begin
        ram_re    = 1'b1;
        done_d    = 1'b1;
        status_d  = STS_OK;
        use_ram_d = 1'b1;
        last_d    = (cnt_q == CNT_W'(BLOCK_WORDS - 1));
        cnt_d     = cnt_q + CNT_W'(1);
        if (last_d) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    ram_we    = 1'b0;
    ram_waddr = AW'(beat_tgt) * AW'(BLOCK_WORDS) + AW'(beat_item.word_index);
    ram_wdata = beat_item.data_word;
    if (beat_go) begin
      tgt_ok_d = beat_ok;
      tgt_d    = beat_tgt;
      done_d   = 1'b1;
      last_d   = 32'(beat_item.word_index) >= BLOCK_WORDS - 1;
      if (32'(beat_item.word_index) < BLOCK_WORDS &&
          ((beat_item.action == ACT_INSERT && beat_ok == TGT_INSERT) ||
           (beat_item.action == ACT_UPDATE && beat_ok == TGT_UPDATE))) begin
        ram_we   = 1'b1;
        status_d = STS_OK;
      end else if (beat_item.action == ACT_INSERT && beat_ok == TGT_REFUSED) begin
        status_d = STS_DUP;
      end else begin
        status_d = STS_MISS;
      end
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    res_o.status      = status_q;
    res_o.read_word   = use_ram_q ? ram_rdata : '0;
    res_o.last        = last_q;
    res_o.hit_count   = hits_q;
    res_o.query_count = queries_q;
  end

  a_accept_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted word produced no activity");

  a_no_result_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> !done_o)
    else $error("result during search");

  a_hits_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hits_q != $past(hits_q) |-> hits_q == $past(hits_q) + 32'd1 &&
                                queries_q == $past(queries_q))
    else $error("hit counter jumped");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> cnt_q <= CNT_W'(ENTRIES))
    else $error("search ran past chain end");

endmodule
`default_nettype wire
